>>> rtl/mbrot_pkg.sv
package mbrot_pkg;

    localparam int MBROT_MAX_DIM     = 4096;
    localparam int MBROT_FRAC_BITS   = 24;
    localparam int MBROT_QUEUE_DEPTH = 2;

    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int ITER_W  = 16;
    localparam int FIX_W   = 32;
    localparam int LEVEL_W = 8;
    localparam int WIDE_W  = 2 * FIX_W;
    localparam int DVD_W   = COORD_W + FIX_W;

    localparam int S_TDATA_W = ((2 * COORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * COORD_W + ITER_W + 2 * LEVEL_W + 7) / 8) * 8;

    typedef struct packed {
        logic [DIM_W-1:0] canvas_width;
        logic [DIM_W-1:0] canvas_height;
        logic [FIX_W-1:0] re_min;
        logic [FIX_W-1:0] re_max;
        logic [FIX_W-1:0] im_min;
        logic [FIX_W-1:0] im_max;
    } mbrot_map_cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [FIX_W-1:0]   c_re;
        logic [FIX_W-1:0]   c_im;
    } mbrot_point_t;

    function automatic logic [FIX_W-1:0] sat_fix(input logic [WIDE_W-1:0] v);
        logic [FIX_W-1:0] r;
        if (!v[WIDE_W-1] && (|v[WIDE_W-2:FIX_W-1]))
        begin
            r = {1'b0, {(FIX_W-1){1'b1}}};
        end
        else if (v[WIDE_W-1] && !(&v[WIDE_W-2:FIX_W-1]))
        begin
            r = {1'b1, {(FIX_W-1){1'b0}}};
        end
        else
        begin
            r = v[FIX_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/mbrot_div.sv
module mbrot_div
    import mbrot_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DIM_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quot_reg, quot_next;
    logic [DIM_W-1:0] rem_reg, rem_next;
    logic [DIM_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIM_W:0]   rem_shift;
    logic [DIM_W:0]   rem_sub;
    logic             fits;

    assign rem_shift = {rem_reg, quot_reg[DVD_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};
    assign fits      = rem_shift >= {1'b0, dvs_reg};

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[DVD_W-2:0], fits};
            rem_next  = fits ? rem_sub[DIM_W-1:0] : rem_shift[DIM_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

>>> rtl/mbrot_map.sv
module mbrot_map
    import mbrot_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mbrot_map_cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [COORD_W-1:0] in_column,
    input  logic [COORD_W-1:0] in_row,
    output logic               pt_valid,
    input  logic               pt_ready,
    output mbrot_point_t       pt_data
);

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_DIFF = 3'd1;
    localparam logic [2:0] M_MUL  = 3'd2;
    localparam logic [2:0] M_DIV  = 3'd3;
    localparam logic [2:0] M_FIX  = 3'd4;
    localparam logic [2:0] M_PUSH = 3'd5;

    localparam int DIFF_W = FIX_W + 1;
    localparam int PROD_W = COORD_W + 1 + DIFF_W;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0)
        begin
            r = DIM_W'(1);
        end
        else if (32'(d) > 32'(MBROT_MAX_DIM))
        begin
            r = DIM_W'(MBROT_MAX_DIM);
        end
        else
        begin
            r = d;
        end
        return r;
    endfunction

    logic [2:0]                state_reg, state_next;
    logic                      axis_reg, axis_next;
    logic                      start_reg, start_next;
    logic [COORD_W-1:0]        col_reg, col_next;
    logic [COORD_W-1:0]        row_reg, row_next;
    logic signed [DIFF_W-1:0]  diff_re_reg, diff_re_next;
    logic signed [DIFF_W-1:0]  diff_im_reg, diff_im_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [PROD_W-1:0]         quot_reg, quot_next;
    logic [FIX_W-1:0]          cre_reg, cre_next;
    logic [FIX_W-1:0]          cim_reg, cim_next;

    logic [COORD_W-1:0]        mul_coord;
    logic signed [DIFF_W-1:0]  mul_diff;
    logic [PROD_W-1:0]         prod_mag;
    logic [DVD_W-1:0]          div_q;
    logic                      div_done;
    logic [DIM_W-1:0]          div_dvs;
    logic [WIDE_W-1:0]         base_wide;
    logic [WIDE_W-1:0]         quot_wide;
    logic [WIDE_W-1:0]         sum_wide;

    assign mul_coord = axis_reg ? row_reg : col_reg;
    assign mul_diff  = axis_reg ? diff_im_reg : diff_re_reg;
    assign prod_mag  = prod_reg[PROD_W-1] ? (~prod_reg + 1'b1) : prod_reg;
    assign div_dvs   = axis_reg ? clamp_dim(cfg.canvas_height) : clamp_dim(cfg.canvas_width);
    assign base_wide = axis_reg ? {{(WIDE_W-FIX_W){cfg.im_max[FIX_W-1]}}, cfg.im_max}
                                : {{(WIDE_W-FIX_W){cfg.re_min[FIX_W-1]}}, cfg.re_min};
    assign quot_wide = {{(WIDE_W-PROD_W){quot_reg[PROD_W-1]}}, quot_reg};
    assign sum_wide  = axis_reg ? (base_wide - quot_wide) : (base_wide + quot_wide);

    mbrot_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (prod_mag[DVD_W-1:0]),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        start_next   = 1'b0;
        col_next     = col_reg;
        row_next     = row_reg;
        diff_re_next = diff_re_reg;
        diff_im_next = diff_im_reg;
        prod_next    = prod_reg;
        quot_next    = quot_reg;
        cre_next     = cre_reg;
        cim_next     = cim_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (in_valid)
                begin
                    col_next   = in_column;
                    row_next   = in_row;
                    state_next = M_DIFF;
                end
            end
            M_DIFF:
            begin
                diff_re_next = $signed({cfg.re_max[FIX_W-1], cfg.re_max})
                             - $signed({cfg.re_min[FIX_W-1], cfg.re_min});
                diff_im_next = $signed({cfg.im_max[FIX_W-1], cfg.im_max})
                             - $signed({cfg.im_min[FIX_W-1], cfg.im_min});
                axis_next    = 1'b0;
                state_next   = M_MUL;
            end
            M_MUL:
            begin
                prod_next  = $signed({1'b0, mul_coord}) * mul_diff;
                start_next = 1'b1;
                state_next = M_DIV;
            end
            M_DIV:
            begin
                if (div_done)
                begin
                    quot_next  = prod_reg[PROD_W-1]
                               ? (PROD_W'(0) - {{(PROD_W-DVD_W){1'b0}}, div_q})
                               : {{(PROD_W-DVD_W){1'b0}}, div_q};
                    state_next = M_FIX;
                end
            end
            M_FIX:
            begin
                if (axis_reg)
                begin
                    cim_next   = sat_fix(sum_wide);
                    state_next = M_PUSH;
                end
                else
                begin
                    cre_next   = sat_fix(sum_wide);
                    axis_next  = 1'b1;
                    state_next = M_MUL;
                end
            end
            M_PUSH:
            begin
                if (pt_ready)
                begin
                    state_next = M_IDLE;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            axis_reg  <= 1'b0;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg     <= col_next;
        row_reg     <= row_next;
        diff_re_reg <= diff_re_next;
        diff_im_reg <= diff_im_next;
        prod_reg    <= prod_next;
        quot_reg    <= quot_next;
        cre_reg     <= cre_next;
        cim_reg     <= cim_next;
    end

    assign in_ready       = (state_reg == M_IDLE);
    assign pt_valid       = (state_reg == M_PUSH);
    assign pt_data.column = col_reg;
    assign pt_data.row    = row_reg;
    assign pt_data.c_re   = cre_reg;
    assign pt_data.c_im   = cim_reg;

endmodule

>>> rtl/mbrot_fifo.sv
module mbrot_fifo
    import mbrot_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  mbrot_point_t push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output mbrot_point_t pop_data
);

    localparam int DEPTH = MBROT_QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mbrot_point_t     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/mbrot_iter.sv
module mbrot_iter
    import mbrot_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ITER_W-1:0]  max_iterations,
    input  logic               pt_valid,
    output logic               pt_ready,
    input  mbrot_point_t       pt_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COORD_W-1:0] out_column,
    output logic [COORD_W-1:0] out_row,
    output logic [ITER_W-1:0]  iteration_count,
    output logic [LEVEL_W-1:0] red_level,
    output logic [LEVEL_W-1:0] green_level
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_MUL  = 3'd1;
    localparam logic [2:0] B_UPD  = 3'd2;
    localparam logic [2:0] B_RED  = 3'd3;
    localparam logic [2:0] B_SQR  = 3'd4;
    localparam logic [2:0] B_GRN  = 3'd5;

    localparam logic [WIDE_W-1:0] ESC_LIMIT = WIDE_W'(16) << (2 * MBROT_FRAC_BITS);

    function automatic logic [LEVEL_W-1:0] mod255(input logic [2*LEVEL_W-1:0] x);
        logic [LEVEL_W:0] s;
        logic [LEVEL_W:0] t;
        s = {1'b0, x[2*LEVEL_W-1:LEVEL_W]} + {1'b0, x[LEVEL_W-1:0]};
        t = {1'b0, s[LEVEL_W-1:0]} + {{LEVEL_W{1'b0}}, s[LEVEL_W]};
        return (t[LEVEL_W-1:0] == {LEVEL_W{1'b1}}) ? '0 : t[LEVEL_W-1:0];
    endfunction

    logic [2:0]               state_reg, state_next;
    logic [COORD_W-1:0]       col_reg, col_next;
    logic [COORD_W-1:0]       row_reg, row_next;
    logic signed [FIX_W-1:0]  cre_reg, cre_next;
    logic signed [FIX_W-1:0]  cim_reg, cim_next;
    logic signed [FIX_W-1:0]  zr_reg, zr_next;
    logic signed [FIX_W-1:0]  zi_reg, zi_next;
    logic signed [WIDE_W-1:0] rr_reg, rr_next;
    logic signed [WIDE_W-1:0] ii_reg, ii_next;
    logic signed [WIDE_W-1:0] ri_reg, ri_next;
    logic [ITER_W-1:0]        cnt_reg, cnt_next;
    logic [LEVEL_W-1:0]       red_reg, red_next;
    logic [2*LEVEL_W-1:0]     sq_reg, sq_next;
    logic                     ov_reg, ov_next;
    logic [COORD_W-1:0]       ocol_reg, ocol_next;
    logic [COORD_W-1:0]       orow_reg, orow_next;
    logic [ITER_W-1:0]        ocnt_reg, ocnt_next;
    logic [LEVEL_W-1:0]       ored_reg, ored_next;
    logic [LEVEL_W-1:0]       ogrn_reg, ogrn_next;

    logic [WIDE_W-1:0]        mag_sq;
    logic signed [WIDE_W-1:0] re_dif;
    logic signed [WIDE_W-1:0] re_shf;
    logic signed [WIDE_W-1:0] im_shf;
    logic [WIDE_W-1:0]        nr_wide;
    logic [WIDE_W-1:0]        ni_wide;
    logic                     load_out;

    assign mag_sq   = $unsigned(rr_reg) + $unsigned(ii_reg);
    assign re_dif   = rr_reg - ii_reg;
    assign re_shf   = re_dif >>> MBROT_FRAC_BITS;
    assign im_shf   = ri_reg >>> (MBROT_FRAC_BITS - 1);
    assign nr_wide  = $unsigned(re_shf) + {{(WIDE_W-FIX_W){cre_reg[FIX_W-1]}}, cre_reg};
    assign ni_wide  = $unsigned(im_shf) + {{(WIDE_W-FIX_W){cim_reg[FIX_W-1]}}, cim_reg};
    assign load_out = (state_reg == B_GRN) && (!ov_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        cre_next   = cre_reg;
        cim_next   = cim_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        rr_next    = rr_reg;
        ii_next    = ii_reg;
        ri_next    = ri_reg;
        cnt_next   = cnt_reg;
        red_next   = red_reg;
        sq_next    = sq_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (pt_valid)
                begin
                    col_next   = pt_data.column;
                    row_next   = pt_data.row;
                    cre_next   = $signed(pt_data.c_re);
                    cim_next   = $signed(pt_data.c_im);
                    zr_next    = '0;
                    zi_next    = '0;
                    cnt_next   = '0;
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                if (cnt_reg >= max_iterations)
                begin
                    state_next = B_RED;
                end
                else
                begin
                    rr_next    = zr_reg * zr_reg;
                    ii_next    = zi_reg * zi_reg;
                    ri_next    = zr_reg * zi_reg;
                    state_next = B_UPD;
                end
            end
            B_UPD:
            begin
                if (mag_sq >= ESC_LIMIT)
                begin
                    state_next = B_RED;
                end
                else
                begin
                    zr_next    = $signed(sat_fix(nr_wide));
                    zi_next    = $signed(sat_fix(ni_wide));
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = B_MUL;
                end
            end
            B_RED:
            begin
                red_next   = mod255(cnt_reg);
                state_next = B_SQR;
            end
            B_SQR:
            begin
                sq_next    = (2*LEVEL_W)'(red_reg) * (2*LEVEL_W)'(red_reg);
                state_next = B_GRN;
            end
            B_GRN:
            begin
                if (load_out)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ov_next   = ov_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        ocnt_next = ocnt_reg;
        ored_next = ored_reg;
        ogrn_next = ogrn_reg;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        if (load_out)
        begin
            ov_next   = 1'b1;
            ocol_next = col_reg;
            orow_next = row_reg;
            ocnt_next = cnt_reg;
            ored_next = red_reg;
            ogrn_next = mod255(sq_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg  <= col_next;
        row_reg  <= row_next;
        cre_reg  <= cre_next;
        cim_reg  <= cim_next;
        zr_reg   <= zr_next;
        zi_reg   <= zi_next;
        rr_reg   <= rr_next;
        ii_reg   <= ii_next;
        ri_reg   <= ri_next;
        cnt_reg  <= cnt_next;
        red_reg  <= red_next;
        sq_reg   <= sq_next;
        ocol_reg <= ocol_next;
        orow_reg <= orow_next;
        ocnt_reg <= ocnt_next;
        ored_reg <= ored_next;
        ogrn_reg <= ogrn_next;
    end

    assign pt_ready        = (state_reg == B_IDLE);
    assign out_valid       = ov_reg;
    assign out_column      = ocol_reg;
    assign out_row         = orow_reg;
    assign iteration_count = ocnt_reg;
    assign red_level       = ored_reg;
    assign green_level     = ogrn_reg;

endmodule

>>> rtl/mandelbrot_escape_time_pixel.sv
// Channel  Dir  Handshake                    Payload, low bits first
// s_axis   in   s_axis_tvalid/s_axis_tready  pixel_column, pixel_row
// m_axis   out  m_axis_tvalid/m_axis_tready  out_column, out_row, iteration_count,
//                                            red_level, green_level
// cfg      in   cfg_valid/cfg_ready          cfg_index (register 0..6), cfg_data
//
// Front end maps a pixel with two runs of one radix-2 divider over a 44-bit dividend.
// Back end runs each z step as three 32x32 products, then add and saturate, and after the
// last step forms the red and green levels; the default iteration limit is 255.
// Reset loads the default view and empties the two-entry queue; cfg_ready is always high.
// A stalled m_axis holds the result register while the next pixel iterates behind it.
module mandelbrot_escape_time_pixel
    import mbrot_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // pixel_column, pixel_row
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // out_column, out_row, iteration_count,
                                                // red_level, green_level
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [FIX_W-1:0]     cfg_data
);

    localparam logic [2:0] REG_CANVAS_WIDTH  = 3'd0;
    localparam logic [2:0] REG_CANVAS_HEIGHT = 3'd1;
    localparam logic [2:0] REG_MAX_ITER      = 3'd2;
    localparam logic [2:0] REG_RE_MIN        = 3'd3;
    localparam logic [2:0] REG_RE_MAX        = 3'd4;
    localparam logic [2:0] REG_IM_MIN        = 3'd5;
    localparam logic [2:0] REG_IM_MAX        = 3'd6;

    mbrot_map_cfg_t     map_cfg_reg, map_cfg_next;
    logic [ITER_W-1:0]  max_iter_reg, max_iter_next;

    logic               pt_push_valid;
    logic               pt_push_ready;
    mbrot_point_t       pt_push_data;
    logic               pt_pop_valid;
    logic               pt_pop_ready;
    mbrot_point_t       pt_pop_data;

    logic [COORD_W-1:0] res_column;
    logic [COORD_W-1:0] res_row;
    logic [ITER_W-1:0]  res_count;
    logic [LEVEL_W-1:0] res_red;
    logic [LEVEL_W-1:0] res_green;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        map_cfg_next  = map_cfg_reg;
        max_iter_next = max_iter_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CANVAS_WIDTH:  map_cfg_next.canvas_width  = cfg_data[DIM_W-1:0];
                REG_CANVAS_HEIGHT: map_cfg_next.canvas_height = cfg_data[DIM_W-1:0];
                REG_MAX_ITER:      max_iter_next              = cfg_data[ITER_W-1:0];
                REG_RE_MIN:        map_cfg_next.re_min        = cfg_data;
                REG_RE_MAX:        map_cfg_next.re_max        = cfg_data;
                REG_IM_MIN:        map_cfg_next.im_min        = cfg_data;
                REG_IM_MAX:        map_cfg_next.im_max        = cfg_data;
                default:
                begin
                    map_cfg_next = map_cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_cfg_reg.canvas_width  <= DIM_W'(1920);
            map_cfg_reg.canvas_height <= DIM_W'(1080);
            map_cfg_reg.re_min        <= FIX_W'(-31876710);
            map_cfg_reg.re_max        <= FIX_W'(11744051);
            map_cfg_reg.im_min        <= FIX_W'(-21810381);
            map_cfg_reg.im_max        <= FIX_W'(21810381);
            max_iter_reg              <= ITER_W'(255);
        end
        else
        begin
            map_cfg_reg  <= map_cfg_next;
            max_iter_reg <= max_iter_next;
        end
    end

    mbrot_map u_map
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (map_cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_column (s_axis_tdata[COORD_W-1:0]),
        .in_row    (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .pt_valid  (pt_push_valid),
        .pt_ready  (pt_push_ready),
        .pt_data   (pt_push_data)
    );

    mbrot_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (pt_push_valid),
        .push_ready (pt_push_ready),
        .push_data  (pt_push_data),
        .pop_valid  (pt_pop_valid),
        .pop_ready  (pt_pop_ready),
        .pop_data   (pt_pop_data)
    );

    mbrot_iter u_iter
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .max_iterations  (max_iter_reg),
        .pt_valid        (pt_pop_valid),
        .pt_ready        (pt_pop_ready),
        .pt_data         (pt_pop_data),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_column      (res_column),
        .out_row         (res_row),
        .iteration_count (res_count),
        .red_level       (res_red),
        .green_level     (res_green)
    );

    assign m_axis_tdata = {res_green, res_red, res_count, res_row, res_column};

endmodule
